/* design/button_debounce_long_press_unit_assert.svh */
// assertion macros for the button debounce unit
// used by the top level only, no other dependencies
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH

// clocked property, masked while reset is asserted
`define BDLP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// clocked property that also holds during reset
`define BDLP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* design/bdlp_pkg.sv */
// shared types, reset values and codes for the button debounce unit
// no dependencies
package bdlp_pkg;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
	localparam logic [15:0] LONG_PRESS_RST = 16'd700;
	localparam logic [15:0] BLINK_RST      = 16'd500;
	localparam logic        LED_LOW_RST    = 1'b1;

	// configuration port widths
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LED_LOW    = 8'd3;

	// event codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	typedef struct packed {
		logic [15:0] settle_ms;
		logic [15:0] long_ms;
		logic [15:0] blink_half_ms;
		logic        led_active_low;
	} cfg_t;

	typedef struct packed {
		logic        raw_prev;
		logic        stable_level;
		logic [31:0] change_time;
		logic [31:0] press_time;
		logic [31:0] press_count;
		logic [31:0] bounce_count;
		logic        ring_state;
		logic        led_state;
		logic [31:0] blink_time;
	} state_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] held_ms;
		logic        is_long;
		logic        ring_on;
		logic        led_pin;
		logic [31:0] press_total;
		logic [31:0] bounce_total;
	} result_t;

endpackage

/* design/bdlp_if.sv */
// valid/ready channel interfaces: button samples, results, register writes
// depends on bdlp_pkg
interface bdlp_sample_if;
	logic        valid;
	logic        ready;
	logic        raw_pressed;
	logic [31:0] now_ms;

	modport source (output valid, output raw_pressed, output now_ms, input ready);
	modport sink (input valid, input raw_pressed, input now_ms, output ready);
endinterface

interface bdlp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [31:0] held_ms;
	logic        is_long;
	logic        ring_on;
	logic        led_pin;
	logic [31:0] press_total;
	logic [31:0] bounce_total;

	modport source (output valid, output event_res, output held_ms, output is_long,
		output ring_on, output led_pin, output press_total, output bounce_total,
		input ready);
	modport sink (input valid, input event_res, input held_ms, input is_long,
		input ring_on, input led_pin, input press_total, input bounce_total,
		output ready);
endinterface

interface bdlp_cfg_if import bdlp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/bdlp_cfg.sv */
// configuration register file for the button debounce unit
// depends on bdlp_pkg and bdlp_if
module bdlp_cfg import bdlp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bdlp_cfg_if.sink      cfg,
	output cfg_t          regs
);

	assign cfg.ready = 1'b1;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.settle_ms      <= DEBOUNCE_RST;
			regs.long_ms        <= LONG_PRESS_RST;
			regs.blink_half_ms  <= BLINK_RST;
			regs.led_active_low <= LED_LOW_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DEBOUNCE:   regs.settle_ms      <= cfg.data;
				REG_LONG_PRESS: regs.long_ms        <= cfg.data;
				REG_BLINK:      regs.blink_half_ms  <= cfg.data;
				REG_LED_LOW:    regs.led_active_low <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

/* design/bdlp_step.sv */
// next-state and result logic for one button sample
// depends on bdlp_pkg
module bdlp_step import bdlp_pkg::*; (
	input  state_t      st,
	input  cfg_t        regs,
	input  logic        raw,
	input  logic [31:0] now,
	output state_t      nxt,
	output result_t     res
);

	logic        flip;
	logic [31:0] since_change;
	logic [31:0] held;
	logic [31:0] since_blink;
	logic        accept;

	// raw flip tracking; a flip restarts the debounce window at zero
	assign flip         = raw != st.raw_prev;
	assign since_change = flip ? 32'd0 : now - st.change_time;
	assign accept       = (raw != st.stable_level) && (since_change >= {16'd0, regs.settle_ms});
	assign held         = now - st.press_time;
	assign since_blink  = now - st.blink_time;

	always_comb begin
		nxt = st;
		res = '0;
		res.event_res = EV_NONE;

		// flips against the stable level count as bounces
		if (flip) begin
			nxt.raw_prev    = raw;
			nxt.change_time = now;
			if (raw != st.stable_level) begin
				nxt.bounce_count = st.bounce_count + 32'd1;
			end
		end

		// debounced press or release
		if (accept) begin
			nxt.stable_level = raw;
			if (raw) begin
				nxt.press_time  = now;
				nxt.press_count = st.press_count + 32'd1;
				nxt.ring_state  = ~st.ring_state;
				res.event_res   = EV_PRESS;
			end else begin
				res.held_ms   = held;
				res.is_long   = held >= {16'd0, regs.long_ms};
				res.event_res = EV_RELEASE;
			end
		end

		// status led blink
		if (since_blink >= {16'd0, regs.blink_half_ms}) begin
			nxt.blink_time = now;
			nxt.led_state  = ~st.led_state;
		end

		res.ring_on      = nxt.ring_state;
		res.led_pin      = nxt.led_state ^ regs.led_active_low;
		res.press_total  = nxt.press_count;
		res.bounce_total = nxt.bounce_count;
	end

endmodule

/* design/button_debounce_long_press_unit.sv */
// Button debounce unit with long-press classification and status LED.
// Channels: sample (sink) takes raw_pressed and a millisecond timestamp;
// result (source) returns one word per sample: event, held time, long
// flag, ring output, LED pin, press and bounce totals; cfg (sink) writes
// settle time, long-press threshold, blink half period and LED polarity
// by index 0..3, always ready, to be written only while no sample is in flight.
// Path: an accepted sample is held in the input register, then in the
// result register, which drives the result channel.
// Throughput: one sample per cycle unless stalled; the step is one pass
// of compare and update logic between the input and state/result registers.
// A stalled receiver holds the result register; one more sample is taken
// into the input register, after which sample.ready drops until the
// result is taken.
// Reset: asynchronous, active low; clears all timing and count state,
// the ring and LED, and loads the register defaults (30, 700, 500, 1).
// Depends on bdlp_pkg, bdlp_if, bdlp_cfg, bdlp_step and the assert macros.
`include "button_debounce_long_press_unit_assert.svh"

module button_debounce_long_press_unit import bdlp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bdlp_sample_if.sink   sample,
	bdlp_result_if.source result,
	bdlp_cfg_if.sink      cfg
);

	cfg_t        regs;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res_nxt;
	result_t     res_q;
	logic        out_valid_q;
	logic        valid_s1;
	logic        raw_s1;
	logic [31:0] now_s1;
	logic        advance;

	bdlp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bdlp_step u_step (
		.st   (state_q),
		.regs (regs),
		.raw  (raw_s1),
		.now  (now_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// handshake: input stage moves when the result register is free
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_pressed;
			now_s1 <= sample.now_ms;
		end
	end

	// button state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.event_res    = res_q.event_res;
	assign result.held_ms      = res_q.held_ms;
	assign result.is_long      = res_q.is_long;
	assign result.ring_on      = res_q.ring_on;
	assign result.led_pin      = res_q.led_pin;
	assign result.press_total  = res_q.press_total;
	assign result.bounce_total = res_q.bounce_total;

	// checks
	`BDLP_ASSERT_ALWAYS(a_ready_when_empty, clk, !valid_s1 |-> sample.ready,
		"sample channel not ready with empty input stage")
	`BDLP_ASSERT(a_state_hold, clk, arst_n,
		!advance |=> ($stable(state_q.press_count) && $stable(state_q.ring_state)),
		"button state changed without a sample")
	`BDLP_ASSERT(a_press_counts, clk, arst_n,
		(advance && res_nxt.event_res == EV_PRESS) |=>
			(state_q.press_count == $past(state_q.press_count) + 32'd1 &&
			state_q.ring_state != $past(state_q.ring_state)),
		"press event without count and ring toggle")
	`BDLP_ASSERT(a_release_fields, clk, arst_n,
		(out_valid_q && res_q.event_res != EV_RELEASE) |-> (!res_q.is_long && res_q.held_ms == 32'd0),
		"held time or long flag set outside a release")

endmodule
